FILE: hw/rtl/rhpm_pkg.sv
// ----------------------------------------------------------------------------
// Rolling hash pattern matcher package
// Shared widths and codes for the matcher.
// ----------------------------------------------------------------------------
package rhpm_pkg;

  localparam int unsigned ModW     = 15;
  localparam int unsigned LenW     = 7;
  localparam int unsigned IdxW     = 32;
  localparam int unsigned MissW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] RegModulus = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPatLen  = 1'b1;

  localparam logic KindPattern = 1'b0;
  localparam logic KindText    = 1'b1;

endpackage

FILE: hw/rtl/rolling_hash_pattern_matcher_unit.sv
// ----------------------------------------------------------------------------
// Rolling hash pattern matcher
// Rabin-Karp search over a byte stream with a configurable hash modulus.
// ----------------------------------------------------------------------------
// Pattern bytes (kind 0) load a pattern of up to MAX_PATTERN bytes; text bytes
// (kind 1) roll a window hash over the last m bytes. On a hash hit the window
// is checked byte by byte and a true match emits its start index together
// with the count of spurious hits since the text started. One item is worked
// on at a time and the input is not ready until it is done. All modular work
// runs through one shared step unit, acc = (2*acc + bit*mcand) mod q, fed one
// operand bit per cycle MSB first; a Horner pass over {hash, byte} gives
// (hash*256 + byte) mod q even when hash is not below q.
// Work per input transfer:
//   - first byte of a pattern: hash update over {hash, byte}
//   - later pattern bytes: leading power update, then the hash update
//   - pattern bytes past m: dropped
//   - text byte while the window fills: hash update
//   - text byte once the window is full: reduce the window hash, reduce the
//     leading power, form old*power, then shift in the new byte
//   - on a hash hit, for each compared byte a read from the pattern store and
//     the window ring, then the compare, stopping at the first mismatch or
//     after m bytes, plus loading the output register on a true match; that
//     step stretches while the output register still holds an untaken result.
// Configuration writes are taken only while idle with no input offered.
// No clearing pass is needed after reset.
module rolling_hash_pattern_matcher_unit #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,   // [0] kind, [1] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] match_index, [47:32] spurious_hits
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [rhpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rhpm_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CW   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned QW   = rhpm_pkg::ModW;
  localparam int unsigned LW   = rhpm_pkg::LenW;
  localparam int unsigned MW   = rhpm_pkg::MissW;
  localparam int unsigned MulW = QW + 8;

  // Sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StPLead = 4'd1;  // leading_power = lp*256 mod q
  localparam logic [3:0] StPHash = 4'd2;  // pattern_hash = ph*256 + byte mod q
  localparam logic [3:0] StTRedH = 4'd3;  // window_hash mod q
  localparam logic [3:0] StTRedL = 4'd4;  // leading_power mod q
  localparam logic [3:0] StTLead = 4'd5;  // old byte * leading_power mod q
  localparam logic [3:0] StTHash = 4'd6;  // shift the new byte into the hash
  localparam logic [3:0] StVRead = 4'd7;  // issue compare read
  localparam logic [3:0] StVCmp  = 4'd8;  // compare read data
  localparam logic [3:0] StOut   = 4'd9;  // wait for the output register

  logic [QW-1:0] mod_q, q_eff;
  logic [LW-1:0] plen_q;
  logic [CW-1:0] m_eff;

  assign q_eff = (mod_q < QW'(2)) ? QW'(2) : mod_q;
  always_comb begin
    if (plen_q == '0) m_eff = CW'(1);
    else if (32'(plen_q) > MAX_PATTERN) m_eff = CW'(MAX_PATTERN);
    else m_eff = CW'(plen_q);
  end

  logic [3:0] state_q;
  logic [QW-1:0] phash_q, whash_q, lpow_q, hred_q, acc_q, mcand_q;
  logic [MulW-1:0] mul_q;
  logic [4:0] cnt_q;
  logic [CW-1:0] pcount_q, wfill_q, vcnt_q;
  logic [AW-1:0] slot_q;
  logic [31:0] tpos_q;
  logic [MW-1:0] miss_q;
  logic [7:0] byte_q;
  logic ovalid_q;
  logic [31:0] oidx_q;
  logic [MW-1:0] omiss_q;

  logic [7:0] pat_mem [MAX_PATTERN];
  logic [7:0] ring_mem [MAX_PATTERN];
  logic [7:0] prd_q, rrd_q;

  // Shared step unit: both operands stay below q, so one subtract each.
  logic [QW:0] dbl, dbl_r, addv, addv_r;
  logic [QW-1:0] step_res;
  logic step_last;
  always_comb begin
    dbl      = {acc_q, 1'b0};
    dbl_r    = (dbl >= {1'b0, q_eff}) ? dbl - {1'b0, q_eff} : dbl;
    addv     = dbl_r + (mul_q[MulW-1] ? {1'b0, mcand_q} : '0);
    addv_r   = (addv >= {1'b0, q_eff}) ? addv - {1'b0, q_eff} : addv;
    step_res = addv_r[QW-1:0];
  end
  assign step_last = (cnt_q == 5'd1);

  // Drop the leading byte: (h + q - lead) mod q, with h and lead below q.
  logic [QW:0] diff_raw, diff_red;
  logic [QW-1:0] diff_mod;
  always_comb begin
    diff_raw = {1'b0, hred_q} + {1'b0, q_eff} - {1'b0, step_res};
    diff_red = (diff_raw >= {1'b0, q_eff}) ? diff_raw - {1'b0, q_eff} : diff_raw;
    diff_mod = diff_red[QW-1:0];
  end

  logic in_acc, cfg_acc, out_free;
  logic in_kind, in_start;
  logic [7:0] in_byte;
  logic [CW-1:0] pc_eff, fill_eff;
  logic pat_take;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = (state_q == StIdle) && !s_axis_tvalid;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign out_free      = !ovalid_q || m_axis_tready;

  assign in_kind  = s_axis_tuser[0];
  assign in_start = s_axis_tuser[1];
  assign in_byte  = s_axis_tdata;
  assign pc_eff   = in_start ? '0 : pcount_q;
  assign fill_eff = in_start ? '0 : wfill_q;
  assign pat_take = in_acc && (in_kind == rhpm_pkg::KindPattern) && (pc_eff < m_eff);

  // Ring slot of the oldest window byte; during a compare, advance by vcnt.
  logic [31:0] ring_sum, ring_wrap;
  logic [AW-1:0] ring_raddr, slot_next;
  always_comb begin
    ring_sum  = 32'(slot_q) + MAX_PATTERN - 32'(m_eff) +
                ((state_q == StVRead) ? 32'(vcnt_q) : 32'd0);
    ring_wrap = (ring_sum >= MAX_PATTERN) ? ring_sum - MAX_PATTERN : ring_sum;
    ring_raddr = AW'(ring_wrap);
  end
  assign slot_next = (32'(slot_q) == MAX_PATTERN - 1) ? '0 : slot_q + AW'(1);

  logic hit;
  assign hit = ({1'b0, wfill_q} + (CW + 1)'(1) >= {1'b0, m_eff}) &&
               (pcount_q == m_eff) && (step_res == phash_q);

  always_ff @(posedge clk_i) begin
    if (pat_take) pat_mem[AW'(pc_eff)] <= in_byte;
    if (state_q == StTHash && step_last) ring_mem[slot_q] <= byte_q;
    prd_q <= pat_mem[AW'(vcnt_q)];
    rrd_q <= ring_mem[ring_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mod_q    <= QW'(101);
      plen_q   <= LW'(1);
      phash_q  <= '0;
      whash_q  <= '0;
      lpow_q   <= QW'(1);
      hred_q   <= '0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mul_q    <= '0;
      cnt_q    <= '0;
      pcount_q <= '0;
      wfill_q  <= '0;
      vcnt_q   <= '0;
      slot_q   <= '0;
      tpos_q   <= '0;
      miss_q   <= '0;
      byte_q   <= '0;
      ovalid_q <= 1'b0;
      oidx_q   <= '0;
      omiss_q  <= '0;
    end else begin
      if (cfg_acc) begin
        if (cfg_index_i == rhpm_pkg::RegModulus) mod_q <= cfg_data_i;
        else if (cfg_index_i == rhpm_pkg::RegPatLen) plen_q <= cfg_data_i[LW-1:0];
      end
      if (state_q == StOut && out_free) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_acc) begin
          byte_q <= in_byte;
          if (in_kind == rhpm_pkg::KindPattern) begin
            if (in_start) begin
              pcount_q <= '0;
              phash_q  <= '0;
              lpow_q   <= QW'(1);
            end
            if (pc_eff < m_eff) begin
              acc_q   <= '0;
              mcand_q <= QW'(1);
              cnt_q   <= 5'd23;
              if (pc_eff != '0) begin
                mul_q   <= {lpow_q, 8'h00};
                state_q <= StPLead;
              end else begin
                mul_q   <= {in_start ? QW'(0) : phash_q, in_byte};
                state_q <= StPHash;
              end
            end
          end else begin
            if (in_start) begin
              tpos_q <= '0; whash_q <= '0; wfill_q <= '0; miss_q <= '0;
            end
            acc_q   <= '0;
            mcand_q <= QW'(1);
            if (fill_eff < m_eff) begin
              mul_q   <= {in_start ? QW'(0) : whash_q, in_byte};
              cnt_q   <= 5'd23;
              state_q <= StTHash;
            end else begin
              mul_q   <= {whash_q, 8'h00};
              cnt_q   <= 5'd15;
              state_q <= StTRedH;
            end
          end
        end
        StPLead: begin
          if (step_last) begin
            lpow_q  <= step_res;
            acc_q   <= '0;
            mul_q   <= {phash_q, byte_q};
            cnt_q   <= 5'd23;
            state_q <= StPHash;
          end else begin
            acc_q <= step_res; mul_q <= mul_q << 1; cnt_q <= cnt_q - 5'd1;
          end
        end
        StPHash: begin
          if (step_last) begin
            phash_q  <= step_res;
            pcount_q <= pcount_q + CW'(1);
            state_q  <= StIdle;
          end else begin
            acc_q <= step_res; mul_q <= mul_q << 1; cnt_q <= cnt_q - 5'd1;
          end
        end
        StTRedH: begin
          if (step_last) begin
            hred_q  <= step_res;
            acc_q   <= '0;
            mul_q   <= {lpow_q, 8'h00};
            cnt_q   <= 5'd15;
            state_q <= StTRedL;
          end else begin
            acc_q <= step_res; mul_q <= mul_q << 1; cnt_q <= cnt_q - 5'd1;
          end
        end
        StTRedL: begin
          if (step_last) begin
            // rrd_q holds the oldest window byte by now
            acc_q   <= '0;
            mcand_q <= step_res;
            mul_q   <= {rrd_q, QW'(0)};
            cnt_q   <= 5'd8;
            state_q <= StTLead;
          end else begin
            acc_q <= step_res; mul_q <= mul_q << 1; cnt_q <= cnt_q - 5'd1;
          end
        end
        StTLead: begin
          if (step_last) begin
            acc_q   <= diff_mod;
            mcand_q <= QW'(1);
            mul_q   <= {byte_q, QW'(0)};
            cnt_q   <= 5'd8;
            state_q <= StTHash;
          end else begin
            acc_q <= step_res; mul_q <= mul_q << 1; cnt_q <= cnt_q - 5'd1;
          end
        end
        StTHash: begin
          if (step_last) begin
            whash_q <= step_res;
            slot_q  <= slot_next;
            if (wfill_q < m_eff) wfill_q <= wfill_q + CW'(1);
            if (hit) begin
              vcnt_q  <= '0;
              state_q <= StVRead;
            end else begin
              tpos_q  <= tpos_q + 32'd1;
              state_q <= StIdle;
            end
          end else begin
            acc_q <= step_res; mul_q <= mul_q << 1; cnt_q <= cnt_q - 5'd1;
          end
        end
        StVRead: state_q <= StVCmp;
        StVCmp: begin
          if (prd_q != rrd_q) begin
            if (miss_q != '1) miss_q <= miss_q + MW'(1);
            tpos_q  <= tpos_q + 32'd1;
            state_q <= StIdle;
          end else if (vcnt_q == m_eff - CW'(1)) begin
            state_q <= StOut;
          end else begin
            vcnt_q  <= vcnt_q + CW'(1);
            state_q <= StVRead;
          end
        end
        StOut: if (out_free) begin
          oidx_q  <= tpos_q - (32'(m_eff) - 32'd1);
          omiss_q <= miss_q;
          tpos_q  <= tpos_q + 32'd1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {omiss_q, oidx_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q && $stable(m_axis_tdata))
    else $error("result dropped or changed while waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !s_axis_tready && !cfg_ready_o)
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> acc_q < q_eff)
    else $error("accumulator not reduced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= StOut)
    else $error("illegal state");

endmodule

FILE: sim/rolling_hash_pattern_matcher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling hash pattern matcher testbench
// Drives pattern and text bytes through the input stream with random gaps and
// output stalls. A behavioral matcher predicts each match, and the output
// stream is checked against it field by field. The run steps through several
// modulus and pattern length settings, the smallest and largest among them.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_matcher_unit_tb;

  localparam int unsigned Depth     = 64;
  localparam int unsigned CycleCap  = 3000000;

  typedef struct packed {
    logic [rhpm_pkg::MissW-1:0] misses;
    logic [rhpm_pkg::IdxW-1:0]  start;
  } match_t;

  typedef struct {
    logic       kind;
    logic [7:0] value;
    logic       restart;
    logic       typed;   // expected match typed in below
    match_t     want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_value
  logic [1:0]  s_axis_tuser;   // [0] kind, [1] start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [31:0] match_index, [47:32] spurious_hits
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [rhpm_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [rhpm_pkg::CfgDataW-1:0] cfg_data_i;

  // Matcher model state
  logic [14:0] hash_mod;
  logic [6:0]  pat_len;
  logic [7:0]  pat_bytes [Depth];
  logic [7:0]  ring [Depth];
  int unsigned pat_hash, win_hash, lead_pow, pat_cnt, text_pos, misses, slot, fill;

  match_t      pending_matches [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned pushed = 0;
  bit          quiet;   // stretch with no idling on either side

  rolling_hash_pattern_matcher_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic int unsigned eff_mod();
    return (hash_mod < 2) ? 2 : hash_mod;
  endfunction

  function automatic int unsigned eff_len();
    if (pat_len == 0) return 1;
    if (pat_len > Depth) return Depth;
    return pat_len;
  endfunction

  function automatic void clear_matcher();
    hash_mod = 101; pat_len = 1;
    pat_hash = 0; win_hash = 0; lead_pow = 1; pat_cnt = 0;
    text_pos = 0; misses = 0; slot = 0; fill = 0;
  endfunction

  // Advance the matcher by one byte; hand back the match it yields, if any.
  function automatic bit predict_match(logic kind, logic [7:0] c, logic restart,
                                       output match_t res);
    longint unsigned q, h, lead;
    int unsigned m, old, base;
    bit same;
    q = eff_mod();
    m = eff_len();
    res = '0;
    if (kind == rhpm_pkg::KindPattern) begin
      if (restart) begin
        pat_cnt = 0; pat_hash = 0; lead_pow = 1 % q;
      end
      if (pat_cnt < m) begin
        if (pat_cnt > 0) lead_pow = (longint'(lead_pow) * 256) % q;
        pat_bytes[pat_cnt] = c;
        pat_hash = (longint'(pat_hash) * 256 + c) % q;
        pat_cnt++;
      end
      return 1'b0;
    end
    if (restart) begin
      text_pos = 0; win_hash = 0; fill = 0; misses = 0;
    end
    if (fill < m) begin
      win_hash = (longint'(win_hash) * 256 + c) % q;
      fill++;
    end else begin
      old  = ring[(slot + Depth - m) % Depth];
      h    = win_hash % q;
      lead = (longint'(old) * (lead_pow % q)) % q;
      win_hash = (((h + q - lead) % q) * 256 + c) % q;
    end
    ring[slot] = c;
    slot = (slot + 1) % Depth;
    predict_match = 1'b0;
    if (fill >= m && pat_cnt == m && win_hash == pat_hash) begin
      same = 1'b1;
      base = (slot + Depth - m) % Depth;
      for (int j = 0; j < m; j++)
        if (ring[(base + j) % Depth] != pat_bytes[j]) same = 1'b0;
      if (same) begin
        res.start  = text_pos - (m - 1);
        res.misses = misses[15:0];
        predict_match = 1'b1;
      end else if (misses < 16'hFFFF) begin
        misses++;
      end
    end
    text_pos++;
  endfunction

  // Output side: random stalls, compare each transfer with the oldest match.
  always @(posedge clk_i) begin
    match_t want;
    cycles <= cycles + 1;
    if (rst_ni) begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 36);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_matches.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected match: index %0d misses %0d",
                     m_axis_tdata[31:0], m_axis_tdata[47:32]);
        end else begin
          want = pending_matches.pop_front();
          if (m_axis_tdata[31:0] !== want.start || m_axis_tdata[47:32] !== want.misses) begin
            errors++;
            if (errors <= 10)
              $display("match mismatch: expected index %0d misses %0d, got %0d %0d",
                       want.start, want.misses, m_axis_tdata[31:0], m_axis_tdata[47:32]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleCap) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Hold tvalid high after the transfer; the next caller drives it again.
  task automatic send_byte(logic kind, logic [7:0] c, logic restart);
    match_t res;
    while (!quiet && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= {restart, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_match(kind, c, restart, res)) begin
      pending_matches = {pending_matches, res};
      pushed++;
    end
  endtask

  // Hold until every match has come, then let the last item drain.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rhpm_pkg::CfgIdxW-1:0] idx, int unsigned value);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b1;
    cfg_index_i   <= idx;
    cfg_data_i    <= value[rhpm_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == rhpm_pkg::RegModulus) hash_mod = value[14:0];
    else pat_len = value[6:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load a pattern of the current length (sometimes short or long).
  task automatic load_pattern(ref logic [7:0] pat [Depth], input int unsigned n,
                              input int unsigned alpha);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(alpha - 1));
      if (i < Depth) pat[i] = b;
      send_byte(rhpm_pkg::KindPattern, b, i == 0);
    end
  endtask

  // Text mostly from a small alphabet with pattern copies and stray pattern bytes spliced in.
  task automatic send_text(ref logic [7:0] pat [Depth], input int unsigned n,
                           input int unsigned len, input int unsigned alpha);
    int unsigned k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(3) == 0) begin
        for (int j = 0; j < len && k < n; j++) begin
          send_byte(rhpm_pkg::KindText, pat[j], k == 0);
          k++;
        end
      end else begin
        send_byte(($urandom_range(29) == 0) ? rhpm_pkg::KindPattern : rhpm_pkg::KindText,
                  8'($urandom_range(alpha - 1)), k == 0);
        k++;
      end
    end
  endtask

  row_t rows [$];
  logic [7:0] pat [Depth];

  initial begin
    int unsigned len, alpha, sent, prev_pushed;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = rhpm_pkg::RegModulus; cfg_data_i = '0;
    quiet = 1'b0;
    clear_matcher();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings (m = 1), extremes of the byte, restarts,
    // extra pattern bytes, text before a full pattern.
    rows = '{
      '{rhpm_pkg::KindText,    8'h00, 1'b1, 1'b0, '0},   // incomplete pattern: no compare
      '{rhpm_pkg::KindPattern, 8'hFF, 1'b1, 1'b0, '0},
      '{rhpm_pkg::KindPattern, 8'h00, 1'b0, 1'b0, '0},   // extra pattern byte: ignored
      '{rhpm_pkg::KindText,    8'hFF, 1'b1, 1'b1, '{16'd0, 32'd0}},
      '{rhpm_pkg::KindText,    8'h00, 1'b0, 1'b0, '0},
      '{rhpm_pkg::KindText,    8'hFF, 1'b0, 1'b1, '{16'd0, 32'd2}},
      '{rhpm_pkg::KindText,    8'hFF, 1'b0, 1'b1, '{16'd0, 32'd3}},
      '{rhpm_pkg::KindPattern, 8'h00, 1'b1, 1'b0, '0},
      '{rhpm_pkg::KindText,    8'h00, 1'b0, 1'b1, '{16'd0, 32'd4}},
      '{rhpm_pkg::KindText,    8'h65, 1'b0, 1'b0, '0},   // 101 aliases 0: spurious hit
      '{rhpm_pkg::KindText,    8'h00, 1'b0, 1'b1, '{16'd1, 32'd6}},
      '{rhpm_pkg::KindText,    8'h00, 1'b1, 1'b1, '{16'd0, 32'd0}},
      '{rhpm_pkg::KindText,    8'hAA, 1'b0, 1'b0, '0},
      '{rhpm_pkg::KindText,    8'h55, 1'b0, 1'b0, '0}
    };
    foreach (rows[i]) begin
      prev_pushed = pushed;
      send_byte(rows[i].kind, rows[i].value, rows[i].restart);
      if (rows[i].typed) begin
        if (pushed == prev_pushed || pending_matches[$] !== rows[i].want) begin
          errors++;
          if (errors <= 10) $display("directed row %0d: prediction disagrees", i);
        end
      end
    end
    drain();

    // Smallest modulus (q = 2), m = 3: hash hits on last-byte parity alone. No idling.
    quiet = 1'b1;
    write_reg(rhpm_pkg::RegModulus, 0);
    write_reg(rhpm_pkg::RegPatLen, 3);
    load_pattern(pat, 3, 2);
    send_text(pat, 60, 3, 2);
    drain();
    quiet = 1'b0;
    // Largest settings, and pattern length out of range.
    write_reg(rhpm_pkg::RegModulus, 32767);
    write_reg(rhpm_pkg::RegPatLen, 127);
    load_pattern(pat, 64, 4);
    send_text(pat, 140, 64, 4);
    drain();
    write_reg(rhpm_pkg::RegPatLen, 0);
    load_pattern(pat, 1, 256);
    send_text(pat, 30, 1, 4);
    drain();

    // Random phases: mostly short patterns, few long ones.
    sent = 0;
    while (sent < 1500) begin
      write_reg(rhpm_pkg::RegModulus, ($urandom_range(3) == 0) ? $urandom_range(2, 20)
                                                               : $urandom_range(2, 32767));
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 6);
      write_reg(rhpm_pkg::RegPatLen, len);
      alpha = ($urandom_range(4) == 0) ? 256 : $urandom_range(2, 4);
      quiet = ($urandom_range(5) == 0);
      load_pattern(pat, len + (($urandom_range(7) == 0) ? 2 : 0), alpha);
      if ($urandom_range(9) == 0) write_reg(rhpm_pkg::RegPatLen, $urandom_range(1, 6));
      send_text(pat, 40 + len, len, alpha);
      sent += 40 + 2 * len;
      drain();
    end
    quiet = 1'b0;
    drain();

    if (errors == 0 && pending_matches.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rhpm_pkg.sv
hw/rtl/rolling_hash_pattern_matcher_unit.sv
sim/rolling_hash_pattern_matcher_unit_tb.sv
